### rtl/lstk_pkg.sv
// Shared types and constants for the LIFO stack with search.
// No dependencies; imported by lstk_cell, lifo_stack_with_search_unit and the sim checker and testbench.
package lstk_pkg;

    localparam int WORD_W    = 32;
    localparam int FILL_W    = 7;
    localparam int FIDX_W    = 6;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic push;       // shift words one cell toward the bottom
        logic pop;        // shift words one cell toward the top
        logic load_hit;   // latch local compare against the key
        logic shift_hit;  // move hit flags one cell toward the top
    } cell_cmd_t;

endpackage

### rtl/lstk_cell.sv
// One stack slot: word, valid flag and search hit flag.
// Depends on lstk_pkg; instantiated in a chain by lifo_stack_with_search_unit.
module lstk_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lstk_pkg::cell_cmd_t                 cmd,
    input  logic signed [lstk_pkg::WORD_W-1:0]  key,
    input  logic signed [lstk_pkg::WORD_W-1:0]  above_data,
    input  logic                                above_valid,
    input  logic signed [lstk_pkg::WORD_W-1:0]  below_data,
    input  logic                                below_valid,
    input  logic                                below_hit,
    output logic signed [lstk_pkg::WORD_W-1:0]  data,
    output logic                                valid,
    output logic                                hit
);
    import lstk_pkg::*;

    logic signed [WORD_W-1:0] data_reg, data_next;
    logic                     valid_reg, valid_next;
    logic                     hit_reg, hit_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (cmd.push)
        begin
            data_next  = above_data;
            valid_next = above_valid;
        end
        else if (cmd.pop)
        begin
            data_next  = below_data;
            valid_next = below_valid;
        end
        if (cmd.load_hit)
        begin
            hit_next = valid_reg && (data_reg == key);
        end
        else if (cmd.shift_hit)
        begin
            hit_next = below_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

### rtl/lifo_stack_with_search_unit.sv
// LIFO stack of signed words with top-down search, held in a chain of cells (cell 0 = top).
// Push, pop, peek: result strobe in the cycle after accept; busy stays low, one request a cycle.
// Search: hit flags shift one cell a cycle toward the top, and a search holds busy until a hit
//   reaches cell 0 or every occupied cell has passed; on an empty stack busy stays low, as for a pop.
// The receiver cannot stall; each result is shown for one cycle on done.
// Reset (async, active low) empties the stack; slot words are not cleared.
module lifo_stack_with_search_unit
#(
    parameter int DEPTH = lstk_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic signed [lstk_pkg::WORD_W-1:0]  operand,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [lstk_pkg::WORD_W-1:0]  word_out,
    output logic [lstk_pkg::FIDX_W-1:0]         found_index,
    output logic [lstk_pkg::FILL_W-1:0]         fill_level
);
    import lstk_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SRCH = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    logic [FIDX_W-1:0]   fidx_reg, fidx_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    cell_cmd_t           cmd;
    logic signed [WORD_W-1:0] data_w [DEPTH];
    logic                valid_w [DEPTH];
    logic                hit_w   [DEPTH];
    logic                full, empty;
    logic [CNT_W-1:0]    pos;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [WORD_W-1:0] a_data, b_data;
            logic                     a_valid, b_valid, b_hit;
            if (gi == 0)
            begin : g_top
                assign a_data  = operand;
                assign a_valid = 1'b1;
            end
            else
            begin : g_mid_a
                assign a_data  = data_w[gi-1];
                assign a_valid = valid_w[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_bot
                assign b_data  = '0;
                assign b_valid = 1'b0;
                assign b_hit   = 1'b0;
            end
            else
            begin : g_mid_b
                assign b_data  = data_w[gi+1];
                assign b_valid = valid_w[gi+1];
                assign b_hit   = hit_w[gi+1];
            end
            lstk_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .key         (operand),
                .above_data  (a_data),
                .above_valid (a_valid),
                .below_data  (b_data),
                .below_valid (b_valid),
                .below_hit   (b_hit),
                .data        (data_w[gi]),
                .valid       (valid_w[gi]),
                .hit         (hit_w[gi])
            );
        end
    endgenerate

    assign full  = valid_w[DEPTH-1];
    assign empty = !valid_w[0];
    // absolute index from bottom of the cell currently at the top of the hit row
    assign pos   = occ_reg - CNT_W'(1) - CNT_W'(k_reg);

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        k_next      = k_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        word_next   = '0;
        fidx_next   = '0;
        fill_next   = FILL_W'(occ_reg);
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (req_t'(req_type))
                        REQ_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        REQ_POP, REQ_PEEK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                word_next = data_w[0];
                                if (req_t'(req_type) == REQ_POP)
                                begin
                                    cmd.pop  = 1'b1;
                                    occ_next = occ_reg - CNT_W'(1);
                                end
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                done_next    = 1'b0;
                                cmd.load_hit = 1'b1;
                                k_next       = '0;
                                state_next   = S_SRCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                    fill_next = FILL_W'(occ_next);
                end
            end
            S_SRCH:
            begin
                if (hit_w[0])
                begin
                    done_next  = 1'b1;
                    fidx_next  = FIDX_W'(pos[IDX_W-1:0]);
                    state_next = S_IDLE;
                end
                else if (CNT_W'(k_reg) == occ_reg - CNT_W'(1))
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.shift_hit = 1'b1;
                    k_next        = k_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        word_reg   <= word_next;
        fidx_reg   <= fidx_next;
        fill_reg   <= fill_next;
    end

    assign busy        = (state_reg == S_SRCH);
    assign done        = done_reg;
    assign status      = status_reg;
    assign word_out    = word_reg;
    assign found_index = fidx_reg;
    assign fill_level  = fill_reg;

endmodule

### sim/lifo_stack_with_search_checker.sv
// Checker for lifo_stack_with_search_unit: watches the request and result beats,
// keeps its own copy of the stack and compares every result field by field.
// Depends on lstk_pkg for the request and status codes.
`timescale 1ns / 1ps

module lifo_stack_with_search_checker
#(
    parameter int DEPTH = lstk_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic signed [lstk_pkg::WORD_W-1:0]  operand,
    input  logic                                done,
    input  logic [1:0]                          status,
    input  logic signed [lstk_pkg::WORD_W-1:0]  word_out,
    input  logic [lstk_pkg::FIDX_W-1:0]         found_index,
    input  logic [lstk_pkg::FILL_W-1:0]         fill_level,
    output int                                  err_count,
    output int                                  pending
);

    import lstk_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        status_t                    status;
        logic signed [WORD_W-1:0]   word;
        logic [FIDX_W-1:0]          idx;
        logic [FILL_W-1:0]          fill;
    } stack_result_t;

    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       held;
    stack_result_t            expected_results [$];
    int                       mismatch_cnt = 0;
    int                       waiting_cnt = 0;

    assign err_count = mismatch_cnt;
    assign pending   = waiting_cnt;

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Applies one request to the shadow stack and returns what the block must answer.
    function automatic stack_result_t apply_request(input req_t rq,
                                                    input logic signed [WORD_W-1:0] key);
        stack_result_t res;
        int            k;
        logic          hit;
        res.status = ST_OK;
        res.word   = '0;
        res.idx    = '0;
        hit        = 1'b0;
        case (rq)
            REQ_PUSH:
            begin
                if (held >= DEPTH)
                    res.status = ST_OVERFLOW;
                else
                begin
                    shadow_words[held] = key;
                    held++;
                end
            end
            REQ_POP, REQ_PEEK:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.word = shadow_words[held-1];
                    if (rq == REQ_POP)
                        held--;
                end
            end
            default:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    // top-down walk, nearest-to-top match wins
                    for (k = held - 1; k >= 0 && !hit; k--)
                    begin
                        if (shadow_words[k] == key)
                        begin
                            hit     = 1'b1;
                            res.idx = k[FIDX_W-1:0];
                        end
                    end
                    if (!hit)
                        res.status = ST_NOT_FOUND;
                end
            end
        endcase
        res.fill = held[FILL_W-1:0];
        return res;
    endfunction

    task automatic check_result();
        stack_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing expected (status %0d)",
                                      status));
            return;
        end
        want = expected_results.pop_front();
        if (status != want.status)
            report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
        if (word_out != want.word)
            report_mismatch($sformatf("word_out got %0d expected %0d", word_out, want.word));
        if (found_index != want.idx)
            report_mismatch($sformatf("found_index got %0d expected %0d",
                                      found_index, want.idx));
        if (fill_level != want.fill)
            report_mismatch($sformatf("fill_level got %0d expected %0d",
                                      fill_level, want.fill));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            waiting_cnt = 0;
        end
        else
        begin
            // result first: a beat in this cycle belongs to an older request
            if (done)
                check_result();
            if (start && !busy)
                expected_results.push_back(apply_request(req_t'(req_type), operand));
            waiting_cnt = expected_results.size();
        end
    end

endmodule

### sim/tb_lifo_stack_with_search_unit.sv
// Testbench top for lifo_stack_with_search_unit: clock, reset and request stimulus
// (directed corner cases, then fill/drain/mixed random phases); verdict from the checker.
// Depends on lstk_pkg, the unit and lifo_stack_with_search_checker.
`timescale 1ns / 1ps

module tb_lifo_stack_with_search_unit;

    import lstk_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1450;
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 760;
    localparam int PAUSE_AT     = 900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_SIZE    = 12;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 req_type;
    logic signed [WORD_W-1:0]   operand;
    logic                       done;
    logic [1:0]                 status;
    logic signed [WORD_W-1:0]   word_out;
    logic [FIDX_W-1:0]          found_index;
    logic [FILL_W-1:0]          fill_level;
    int                         err_count;
    int                         pending;

    logic                       idle_en;
    int                         sent_cnt [4];
    int                         cycle_cnt = 0;
    logic signed [WORD_W-1:0]   pool [POOL_SIZE];

    lifo_stack_with_search_unit i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .operand     (operand),
        .done        (done),
        .status      (status),
        .word_out    (word_out),
        .found_index (found_index),
        .fill_level  (fill_level)
    );

    lifo_stack_with_search_checker i_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .operand     (operand),
        .done        (done),
        .status      (status),
        .word_out    (word_out),
        .found_index (found_index),
        .fill_level  (fill_level),
        .err_count   (err_count),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Entered and left at a falling edge; start stays high for a back-to-back beat.
    task automatic send_request(input req_t rq, input logic signed [WORD_W-1:0] value);
        while (idle_en && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= rq;
        operand  <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_cnt[int'(rq)]++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_operand();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return pool[$urandom_range(POOL_SIZE-1)];
        else if (r < 92)
            return $urandom;
        else
            return $urandom_range(15);
    endfunction

    function automatic req_t pick_request(input int mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:
                return (r < 85) ? REQ_PUSH : (r < 90) ? REQ_POP : (r < 95) ? REQ_PEEK
                                                                         : REQ_SEARCH;
            MODE_DRAIN:
                return (r < 15) ? REQ_PUSH : (r < 70) ? REQ_POP : (r < 80) ? REQ_PEEK
                                                                         : REQ_SEARCH;
            default:
                return (r < 38) ? REQ_PUSH : (r < 62) ? REQ_POP : (r < 76) ? REQ_PEEK
                                                                         : REQ_SEARCH;
        endcase
    endfunction

    initial
    begin
        int   mode;
        int   phase_left;
        req_t rq;

        start    = 1'b0;
        req_type = REQ_PUSH;
        operand  = '0;
        rst_n    = 1'b0;
        idle_en  = 1'b1;
        foreach (sent_cnt[i])
            sent_cnt[i] = 0;
        pool[0] = 32'sh0000_0000;
        pool[1] = -32'sd1;
        pool[2] = 32'sh7FFF_FFFF;
        pool[3] = 32'sh8000_0000;
        pool[4] = 32'sh5555_5555;
        pool[5] = 32'shAAAA_AAAA;
        for (int i = 6; i < POOL_SIZE; i++)
            pool[i] = $urandom;

        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;

        // empty-stack requests
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_PEEK, -32'sd1);
        send_request(REQ_SEARCH, 32'sd0);
        // extremes and bit patterns, with a duplicate of the max word on top
        send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_PUSH, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH, 32'sh0000_0000);
        send_request(REQ_PUSH, -32'sd1);
        send_request(REQ_PUSH, 32'sh5555_5555);
        send_request(REQ_PUSH, 32'shAAAA_AAAA);
        send_request(REQ_PUSH, 32'sh7FFF_FFFF);
        send_request(REQ_SEARCH, 32'sh7FFF_FFFF);
        send_request(REQ_SEARCH, 32'sh8000_0000);
        send_request(REQ_SEARCH, 32'sh1234_5678);
        send_request(REQ_SEARCH, 32'shFFFF_FFFE);   // one bit off a held word
        send_request(REQ_PEEK, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_PEEK, 32'sd0);
        send_request(REQ_SEARCH, 32'sh7FFF_FFFF);
        repeat (5)
            send_request(REQ_POP, $urandom);
        send_request(REQ_POP, $urandom);

        // first phase fills the stack well past full so overflow is hit
        mode       = MODE_FILL;
        phase_left = 130;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(MODE_MIXED);
                phase_left = $urandom_range(150, 60);
            end
            idle_en = !(i >= QUIET_FROM && i < QUIET_TO);
            if (i == PAUSE_AT)
                wait_drained();
            rq = pick_request(mode);
            send_request(rq, (rq == REQ_PUSH || rq == REQ_SEARCH) ? pick_operand()
                                                                   : $urandom);
            phase_left--;
        end

        wait_drained();
        repeat (DEPTH_DEF + 8)
            @(negedge clk);

        $display("Covered %0d requests: %0d push, %0d pop, %0d peek, %0d search.",
                 sent_cnt[0] + sent_cnt[1] + sent_cnt[2] + sent_cnt[3],
                 sent_cnt[0], sent_cnt[1], sent_cnt[2], sent_cnt[3]);
        $display("Fill, drain and mixed phases with random gaps; %0d field mismatches.",
                 err_count);
        if (err_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
